[rtl/scpa_pkg.sv]
package scpa_pkg;

  // Fixed field widths of the ports.
  localparam int KIND_W   = 1;
  localparam int REQ_W    = 16;
  localparam int CLASS_W  = 4;
  localparam int ID_W     = 5;
  localparam int SIZE_W   = 14;
  localparam int CNT_FLD_W = 5;
  localparam int CFG_W    = 45;

  // Highest number of size classes the block size table supports.
  localparam int MAX_CLASSES = 9;

  typedef enum logic [KIND_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_INVAL = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } bk_state_t;

  // One classified request as it waits between the front and the back.
  // For an allocate, cls is the smallest class whose block covers the request.
  typedef struct packed {
    op_t                  op;
    status_t              pre;
    logic [CLASS_W-1:0]   cls;
    logic [ID_W-1:0]      eid;
  } entry_t;

  localparam logic [SIZE_W-1:0] BLOCK_BYTES [MAX_CLASSES] = '{
    14'd16, 14'd32, 14'd64, 14'd128, 14'd512,
    14'd1024, 14'd2048, 14'd4096, 14'd8192
  };

endpackage

[rtl/scpa_front.sv]
module scpa_front #(
  parameter int NUM_CLASSES = 9,
  parameter int CW = 5
) (
  input  logic [scpa_pkg::KIND_W-1:0]  kind,
  input  logic [scpa_pkg::REQ_W-1:0]   request_size,
  input  logic [scpa_pkg::CLASS_W-1:0] class_id,
  input  logic [scpa_pkg::ID_W-1:0]    entry_id,
  input  logic [CW-1:0]                limit [NUM_CLASSES],
  output scpa_pkg::entry_t             entry
);

  localparam int CLW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic                fit;
  logic [CLW-1:0]      fit_cls;
  logic [CLW-1:0]      free_idx;
  logic                cls_ok;

  // Smallest class whose block covers the request.
  always_comb begin
    fit     = 1'b0;
    fit_cls = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (!fit && (request_size <= scpa_pkg::REQ_W'(scpa_pkg::BLOCK_BYTES[c]))) begin
        fit     = 1'b1;
        fit_cls = CLW'(c);
      end
    end
  end

  assign cls_ok   = class_id < scpa_pkg::CLASS_W'(NUM_CLASSES);
  assign free_idx = class_id[CLW-1:0];

  always_comb begin
    entry.eid = entry_id;
    if (kind == scpa_pkg::OP_ALLOC) begin
      entry.op  = scpa_pkg::OP_ALLOC;
      entry.cls = scpa_pkg::CLASS_W'(fit_cls);
      entry.pre = fit ? scpa_pkg::ST_OK : scpa_pkg::ST_NOMEM;
    end else begin
      entry.op  = scpa_pkg::OP_FREE;
      entry.cls = class_id;
      if (!cls_ok) begin
        entry.pre = scpa_pkg::ST_INVAL;
      end else if (entry_id == '0 ||
                   entry_id > scpa_pkg::ID_W'(limit[free_idx])) begin
        entry.pre = scpa_pkg::ST_RANGE;
      end else begin
        entry.pre = scpa_pkg::ST_OK;
      end
    end
  end

endmodule

[rtl/scpa_queue.sv]
module scpa_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  scpa_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output scpa_pkg::entry_t head,
  output logic             empty
);

  // Two-slot queue.
  scpa_pkg::entry_t slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full  = fill == 2'd2;
  assign empty = fill == 2'd0;
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/scpa_back.sv]
module scpa_back #(
  parameter int NUM_CLASSES = 9,
  parameter int ENTRIES_PER_CLASS = 16,
  parameter int CW = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rebuild,
  input  logic [CW-1:0]                new_limit [NUM_CLASSES],
  input  logic [CW-1:0]                limit [NUM_CLASSES],
  input  logic                         q_empty,
  input  scpa_pkg::entry_t             q_head,
  output logic                         q_pop,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [scpa_pkg::CLASS_W-1:0] granted_class,
  output logic [scpa_pkg::ID_W-1:0]    granted_id,
  output logic [scpa_pkg::SIZE_W-1:0]  granted_size
);

  localparam int CLW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PW    = (ENTRIES_PER_CLASS > 1) ? $clog2(ENTRIES_PER_CLASS) : 1;
  localparam int DEPTH = NUM_CLASSES * ENTRIES_PER_CLASS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  scpa_pkg::bk_state_t state, state_next;

  logic [CW-1:0]           counts [NUM_CLASSES];
  logic [scpa_pkg::ID_W-1:0] mem [DEPTH];
  logic                    valid [DEPTH];

  logic [scpa_pkg::ID_W-1:0] rd_data;
  logic                    rd_valid;
  logic [scpa_pkg::ID_W-1:0] rd_fallback;
  logic [CLW-1:0]          hold_cls, hold_cls_next;

  logic                    hit;
  logic [CLW-1:0]          sel;
  logic [CLW-1:0]          head_idx;
  logic [CLW-1:0]          upd_cls;
  logic                    cnt_dec;
  logic                    cnt_inc;
  logic                    we;
  logic                    re;
  logic [PW-1:0]           pos;
  logic [AW-1:0]           addr;
  logic [scpa_pkg::ID_W-1:0] fallback;

  logic                    done_next;
  scpa_pkg::status_t       status_next;
  logic [scpa_pkg::CLASS_W-1:0] gclass_next;
  logic [scpa_pkg::ID_W-1:0]    gid_next;
  logic [scpa_pkg::SIZE_W-1:0]  gsize_next;

  assign head_idx = q_head.cls[CLW-1:0];

  // First class at or above the fitting class that still has a free entry.
  always_comb begin
    hit = 1'b0;
    sel = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (!hit && (CLW'(c) >= head_idx) && (counts[c] != '0)) begin
        hit = 1'b1;
        sel = CLW'(c);
      end
    end
  end

  always_comb begin
    state_next    = state;
    hold_cls_next = hold_cls;
    q_pop         = 1'b0;
    cnt_dec       = 1'b0;
    cnt_inc       = 1'b0;
    we            = 1'b0;
    re            = 1'b0;
    upd_cls       = head_idx;
    pos           = '0;
    done_next     = 1'b0;
    status_next   = scpa_pkg::ST_OK;
    gclass_next   = '0;
    gid_next      = '0;
    gsize_next    = '0;
    unique case (state)
      scpa_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          done_next = 1'b1;
          if (q_head.pre != scpa_pkg::ST_OK) begin
            status_next = q_head.pre;
          end else if (q_head.op == scpa_pkg::OP_ALLOC) begin
            if (hit) begin
              done_next     = 1'b0;
              upd_cls       = sel;
              cnt_dec       = 1'b1;
              re            = 1'b1;
              pos           = PW'(counts[sel] - CW'(1));
              hold_cls_next = sel;
              state_next    = scpa_pkg::BK_READ;
            end else begin
              status_next = scpa_pkg::ST_NOMEM;
            end
          end else begin
            // A push onto a stack that already holds its full count is dropped.
            if (counts[head_idx] < limit[head_idx]) begin
              cnt_inc = 1'b1;
              we      = 1'b1;
              pos     = PW'(counts[head_idx]);
            end
          end
        end
      end
      scpa_pkg::BK_READ: begin
        done_next   = 1'b1;
        gclass_next = scpa_pkg::CLASS_W'(hold_cls);
        gid_next    = rd_valid ? rd_data : rd_fallback;
        gsize_next  = scpa_pkg::BLOCK_BYTES[scpa_pkg::CLASS_W'(hold_cls)];
        state_next  = scpa_pkg::BK_IDLE;
      end
      default: state_next = scpa_pkg::BK_IDLE;
    endcase
  end

  assign addr     = AW'(upd_cls) * AW'(ENTRIES_PER_CLASS) + AW'(pos);
  // An entry not written since the last rebuild holds id count minus position.
  assign fallback = scpa_pkg::ID_W'(limit[upd_cls] - CW'(pos));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scpa_pkg::BK_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    hold_cls      <= hold_cls_next;
    status        <= status_next;
    granted_class <= gclass_next;
    granted_id    <= gid_next;
    granted_size  <= gsize_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        counts[c] <= '0;
      end
    end else if (rebuild) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        counts[c] <= new_limit[c];
      end
    end else if (cnt_dec) begin
      counts[upd_cls] <= counts[upd_cls] - CW'(1);
    end else if (cnt_inc) begin
      counts[upd_cls] <= counts[upd_cls] + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || rebuild) begin
      for (int i = 0; i < DEPTH; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (we) begin
      valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= q_head.eid;
    end
    if (re) begin
      rd_data     <= mem[addr];
      rd_valid    <= valid[addr];
      rd_fallback <= fallback;
    end
  end

endmodule

[rtl/size_class_pool_allocator_core.sv]
// Channel   Handshake           Beat fields
// -------   -----------------   ---------------------------------------------
// request   start & !busy       kind, request_size, class_id, entry_id
// result    done (one cycle)    status, granted_class, granted_id, granted_size
// config    cfg_we              cfg_wdata (packed per-class entry counts)
//
// A request beat is classified as it is taken and waits in a two-slot queue.
// The back end pops one beat per idle cycle. A free or an error result shows on
// the result ports the cycle after the pop; an allocate that hits goes on to the
// BK_READ state for the registered stack read, and the back end pops no beat there.
// busy is high while the queue is full. Reset is synchronous and empties every
// stack; a config write rebuilds all stacks at its own edge. No receiver stall.
module size_class_pool_allocator_core #(
  parameter int NUM_CLASSES = 9,
  parameter int ENTRIES_PER_CLASS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [scpa_pkg::KIND_W-1:0]   kind,
  input  logic [scpa_pkg::REQ_W-1:0]    request_size,
  input  logic [scpa_pkg::CLASS_W-1:0]  class_id,
  input  logic [scpa_pkg::ID_W-1:0]     entry_id,
  input  logic                          cfg_we,
  input  logic [scpa_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [scpa_pkg::CLASS_W-1:0]  granted_class,
  output logic [scpa_pkg::ID_W-1:0]     granted_id,
  output logic [scpa_pkg::SIZE_W-1:0]   granted_size
);

  // Count width wide enough to hold a full stack.
  localparam int CW = $clog2(ENTRIES_PER_CLASS + 1);

  logic [scpa_pkg::CFG_W-1:0] class_counts;
  logic [CW-1:0]              limit     [NUM_CLASSES];
  logic [CW-1:0]              new_limit [NUM_CLASSES];

  scpa_pkg::entry_t front_entry;
  scpa_pkg::entry_t q_head;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_counts <= '0;
    end else if (cfg_we) begin
      class_counts <= cfg_wdata;
    end
  end

  // Per-class limits, clamped to the stack depth. new_limit follows the
  // data being written so the rebuild happens on the write edge itself.
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (class_counts[c*scpa_pkg::CNT_FLD_W +: scpa_pkg::CNT_FLD_W] >
          scpa_pkg::CNT_FLD_W'(ENTRIES_PER_CLASS)) begin
        limit[c] = CW'(ENTRIES_PER_CLASS);
      end else begin
        limit[c] = CW'(class_counts[c*scpa_pkg::CNT_FLD_W +: scpa_pkg::CNT_FLD_W]);
      end
      if (cfg_wdata[c*scpa_pkg::CNT_FLD_W +: scpa_pkg::CNT_FLD_W] >
          scpa_pkg::CNT_FLD_W'(ENTRIES_PER_CLASS)) begin
        new_limit[c] = CW'(ENTRIES_PER_CLASS);
      end else begin
        new_limit[c] = CW'(cfg_wdata[c*scpa_pkg::CNT_FLD_W +: scpa_pkg::CNT_FLD_W]);
      end
    end
  end

  assign busy   = q_full;
  assign accept = start && !busy;

  scpa_front #(
    .NUM_CLASSES (NUM_CLASSES),
    .CW          (CW)
  ) u_front (
    .kind         (kind),
    .request_size (request_size),
    .class_id     (class_id),
    .entry_id     (entry_id),
    .limit        (limit),
    .entry        (front_entry)
  );

  scpa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  scpa_back #(
    .NUM_CLASSES       (NUM_CLASSES),
    .ENTRIES_PER_CLASS (ENTRIES_PER_CLASS),
    .CW                (CW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .rebuild       (cfg_we),
    .new_limit     (new_limit),
    .limit         (limit),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .done          (done),
    .status        (status),
    .granted_class (granted_class),
    .granted_id    (granted_id),
    .granted_size  (granted_size)
  );

endmodule

[rtl/scpa_checker.sv]
module scpa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          busy,
  input logic                          done,
  input logic [1:0]                    status,
  input logic [scpa_pkg::CLASS_W-1:0]  granted_class,
  input logic [scpa_pkg::ID_W-1:0]     granted_id,
  input logic [scpa_pkg::SIZE_W-1:0]   granted_size
);

  // Failed requests carry no grant.
  assert property (@(posedge clk) disable iff (rst)
    (done && status != scpa_pkg::ST_OK) |->
      (granted_class == '0 && granted_id == '0 && granted_size == '0))
    else $error("grant fields set on a failed result");

  // A granted block always has a nonzero id and a class in the table.
  assert property (@(posedge clk) disable iff (rst)
    (done && status == scpa_pkg::ST_OK && granted_size != '0) |->
      (granted_id != '0 &&
       granted_class < scpa_pkg::CLASS_W'(scpa_pkg::MAX_CLASSES)))
    else $error("granted entry with zero id or bad class");

  // A grant with no size has no id either: frees return zero fields.
  assert property (@(posedge clk) disable iff (rst)
    (done && granted_size == '0) |-> (granted_id == '0 && granted_class == '0))
    else $error("id or class without block size");

  // Reset empties the queue and the result stage.
  assert property (@(posedge clk) rst |=> (!done && !busy))
    else $error("result or busy right after reset");

endmodule

bind size_class_pool_allocator_core scpa_checker u_scpa_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .granted_class (granted_class),
  .granted_id    (granted_id),
  .granted_size  (granted_size)
);
